// ===== rtl/core/handle_table_engine_defines.svh =====
// Assertion macros shared by the handle table engine RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef HANDLE_TABLE_ENGINE_DEFINES_SVH
`define HANDLE_TABLE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define HTE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTE_ASSERT(lbl, clk, rstn, prop, msg)
`define HTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/hte_pkg.sv =====
// Package for the handle table engine: payload types, codes and helpers.
// Depends on nothing; used by the top level handle_table_engine.
`timescale 1ns / 1ps
package hte_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int ID_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [ID_W-1:0] ID_FREE = 32'h0000_0000;
	localparam logic [ID_W-1:0] ID_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [ID_W-1:0] ID_MIN = 32'h0000_0001;
	localparam logic [ID_W-1:0] ID_MAX = 32'hFFFF_FFFE;
	localparam logic [7:0] INDEX_NONE = 8'hFF;

	localparam logic [2:0] OP_ACTIVATE = 3'd0;
	localparam logic [2:0] OP_INVALIDATE = 3'd1;
	localparam logic [2:0] OP_VALIDATE = 3'd2;
	localparam logic [2:0] OP_ACQUIRE = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic REG_FIRST_ID = 1'b0;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] slot_index;
		logic [ID_W-1:0] handle_id;
	} hte_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_index;
		logic [ID_W-1:0] out_id;
	} hte_rsp_t;

	function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] cur);
		logic [ID_W-1:0] n;
		n = cur + ID_MIN;
		if (n == ID_ALL_ONES || n == ID_FREE) begin
			n = ID_MIN;
		end
		return n;
	endfunction

	function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] v);
		logic [ID_W-1:0] r;
		r = v;
		if (v == ID_FREE) begin
			r = ID_MIN;
		end else if (v == ID_ALL_ONES) begin
			r = ID_MAX;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/hte_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module hte_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/handle_table_engine.sv =====
// Top level of the handle table engine: slot table, ID counter and APB register.
// Depends on hte_pkg, hte_ram and handle_table_engine_defines.svh.
//
// Usage: a transaction on the req channel (req_valid, req_stall, req) carries
// op, slot_index and handle_id. Every request yields exactly one response
// transaction on the rsp channel (rsp_valid, rsp_stall, rsp) with status,
// out_index and out_id. A request is taken at the first cycle the block is
// free; the slot entry is read from the table RAM at that edge and the
// request is held in the stage register valid_s1; from there the response
// is written into the output register rsp_q, which drives rsp_valid and rsp.
// One request is in work at a time: during the table RAM read-modify-write
// no new request is taken. The lowest free slot for activate is found from a
// flip-flop occupancy map at acceptance.
// While rsp_valid is high and rsp_stall holds it, the response stays put and
// no new request is taken. An asynchronous reset marks every slot free and
// unlocked at once (the occupancy map clears; RAM contents are ignored
// until rewritten) and loads first_id and the ID counter with 1.
// first_id is written over APB at byte address 0 and reloads the counter.
`timescale 1ns / 1ps
`include "handle_table_engine_defines.svh"
module handle_table_engine
	import hte_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  hte_req_t              req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output hte_rsp_t              rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ENT_W = ID_W + 1;

	logic                  accept;
	logic                  valid_s1;
	logic [2:0]            op_s1;
	logic [7:0]            idx_s1;
	logic [ID_W-1:0]       hid_s1;
	logic [IDX_W-1:0]      free_idx_s1;
	logic                  free_found_s1;

	logic [SLOT_COUNT-1:0] occ_q;
	logic [ID_W-1:0]       id_counter_q;
	logic [ID_W-1:0]       first_id_q;
	hte_rsp_t              rsp_q;
	logic                  rsp_valid_q;

	logic [IDX_W-1:0]      pick_idx;
	logic                  pick_found;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [ENT_W-1:0]      ram_wdata;
	logic [ENT_W-1:0]      ram_rdata;

	logic                  cfg_wr;
	logic                  in_range;
	logic [IDX_W-1:0]      slot_addr;
	logic                  occ_hit;
	logic [ID_W-1:0]       cur_id;
	logic                  cur_lock;
	logic                  hvalid;

	hte_rsp_t              rsp_next;
	logic                  occ_set;
	logic                  occ_clr;
	logic [IDX_W-1:0]      occ_addr;
	logic                  counter_adv;

	assign accept = req_valid && !req_stall;
	assign req_stall = valid_s1 || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_ID);
	assign prdata = (paddr[2] == REG_FIRST_ID) ? first_id_q : '0;

	always_comb begin
		pick_idx = '0;
		pick_found = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				pick_idx = IDX_W'(i);
				pick_found = 1'b1;
			end
		end
	end

	hte_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(req.slot_index[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.op;
			idx_s1 <= req.slot_index;
			hid_s1 <= req.handle_id;
			free_idx_s1 <= pick_idx;
			free_found_s1 <= pick_found;
		end
	end

	assign in_range = idx_s1 < 8'(SLOT_COUNT);
	assign slot_addr = idx_s1[IDX_W-1:0];
	assign occ_hit = in_range && occ_q[slot_addr];
	assign cur_id = occ_hit ? ram_rdata[ID_W-1:0] : ID_FREE;
	assign cur_lock = occ_hit && ram_rdata[ID_W];
	assign hvalid = in_range && (hid_s1 != ID_FREE) && (cur_id == hid_s1);

	always_comb begin
		rsp_next.status = ST_ERROR;
		rsp_next.out_index = idx_s1;
		rsp_next.out_id = hid_s1;
		ram_we = 1'b0;
		ram_waddr = slot_addr;
		ram_wdata = {1'b0, hid_s1};
		occ_set = 1'b0;
		occ_clr = 1'b0;
		occ_addr = slot_addr;
		counter_adv = 1'b0;
		case (op_s1)
			OP_ACTIVATE: begin
				if (free_found_s1) begin
					rsp_next.status = ST_OK;
					rsp_next.out_index = 8'(free_idx_s1);
					rsp_next.out_id = id_counter_q;
					ram_we = valid_s1;
					ram_waddr = free_idx_s1;
					ram_wdata = {1'b0, id_counter_q};
					occ_set = valid_s1;
					occ_addr = free_idx_s1;
					counter_adv = valid_s1;
				end else begin
					rsp_next.status = ST_FULL;
				end
			end
			OP_INVALIDATE: begin
				if (hvalid && !cur_lock) begin
					rsp_next.status = ST_OK;
					rsp_next.out_index = INDEX_NONE;
					occ_clr = valid_s1;
				end else begin
					rsp_next.status = ST_ERROR;
				end
			end
			OP_VALIDATE: begin
				rsp_next.status = hvalid ? ST_OK : ST_INVALID;
			end
			OP_ACQUIRE: begin
				if (!hvalid) begin
					rsp_next.status = ST_INVALID;
				end else if (cur_lock) begin
					rsp_next.status = ST_ERROR;
				end else begin
					rsp_next.status = ST_OK;
					ram_we = valid_s1;
					ram_wdata = {1'b1, hid_s1};
				end
			end
			OP_RELEASE: begin
				if (hvalid) begin
					rsp_next.status = ST_OK;
					ram_we = valid_s1;
					ram_wdata = {1'b0, hid_s1};
				end else begin
					rsp_next.status = ST_INVALID;
				end
			end
			default: begin
				rsp_next.status = ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			id_counter_q <= ID_MIN;
			first_id_q <= ID_MIN;
			rsp_valid_q <= 1'b0;
		end else begin
			if (occ_set) begin
				occ_q[occ_addr] <= 1'b1;
			end else if (occ_clr) begin
				occ_q[occ_addr] <= 1'b0;
			end
			if (cfg_wr) begin
				first_id_q <= clamp_id(pwdata);
				id_counter_q <= clamp_id(pwdata);
			end else if (counter_adv) begin
				id_counter_q <= next_id(id_counter_q);
			end
			if (valid_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	`HTE_ASSERT(a_no_accept_busy, clk, arst_n, accept |-> !valid_s1, "request taken while busy")
	`HTE_ASSERT(a_single_item, clk, arst_n, valid_s1 |=> !valid_s1, "two requests in work")
	`HTE_ASSERT(a_rsp_follows, clk, arst_n, valid_s1 |=> rsp_valid, "response not loaded")
	`HTE_ASSERT(a_counter_legal, clk, arst_n, (id_counter_q != ID_FREE) && (id_counter_q != ID_ALL_ONES), "ID counter holds a reserved value")
	`HTE_ASSERT(a_act_in_range, clk, arst_n, (valid_s1 && occ_set) |-> (rsp_next.out_index < 8'(SLOT_COUNT)), "activate gave a slot out of range")

endmodule
